// File: hdl/iawn_pkg.sv
// Shared types and constants for the inverse affine warp block.
// Used by every module under hdl except iawn_ram; depends on nothing else.
package iawn_pkg;

   localparam int COEF_W = 32;
   localparam int DIM_W  = 8;
   localparam int POS_W  = 7;
   localparam int PIX_W  = 24;
   localparam int IDX_REG_W = 3;
   localparam int PROD_W = COEF_W + POS_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int REQ_DATA_W = ((2 * POS_W + PIX_W + 7) / 8) * 8;

   typedef enum logic [IDX_REG_W-1:0] {
      REG_COEF_XX = 3'd0,
      REG_COEF_XY = 3'd1,
      REG_COEF_XT = 3'd2,
      REG_COEF_YX = 3'd3,
      REG_COEF_YY = 3'd4,
      REG_COEF_YT = 3'd5,
      REG_WIDTH   = 3'd6,
      REG_HEIGHT  = 3'd7
   } reg_index_type;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_WARP = 1'b1
   } mode_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_xx;
      logic signed [COEF_W-1:0] coef_xy;
      logic signed [COEF_W-1:0] coef_xt;
      logic signed [COEF_W-1:0] coef_yx;
      logic signed [COEF_W-1:0] coef_yy;
      logic signed [COEF_W-1:0] coef_yt;
      logic [DIM_W-1:0]         eff_width;
      logic [DIM_W-1:0]         eff_height;
   } cfg_type;

   typedef struct packed {
      mode_type         mode;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [PIX_W-1:0] pixel;
      logic             dest_out;
   } item_type;

endpackage

// File: hdl/iawn_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module iawn_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/iawn_csr.sv
// Configuration registers of the warp block: six affine coefficients and the image size.
// Depends on iawn_pkg.
module iawn_csr
   import iawn_pkg::*;
#(
   parameter int MAX_SIDE  = 128,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_REG_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_data,
   output cfg_type              cfg
);

   localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;
   localparam logic [DIM_W-1:0]  SIDE_RESET = DIM_W'(128);

   logic [COEF_W-1:0] coef_xx_ff, coef_xy_ff, coef_xt_ff;
   logic [COEF_W-1:0] coef_yx_ff, coef_yy_ff, coef_yt_ff;
   logic [DIM_W-1:0]  width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_xx_ff <= ONE;
         coef_xy_ff <= '0;
         coef_xt_ff <= '0;
         coef_yx_ff <= '0;
         coef_yy_ff <= ONE;
         coef_yt_ff <= '0;
         width_ff   <= SIDE_RESET;
         height_ff  <= SIDE_RESET;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_COEF_XX: coef_xx_ff <= csr_data;
            REG_COEF_XY: coef_xy_ff <= csr_data;
            REG_COEF_XT: coef_xt_ff <= csr_data;
            REG_COEF_YX: coef_yx_ff <= csr_data;
            REG_COEF_YY: coef_yy_ff <= csr_data;
            REG_COEF_YT: coef_yt_ff <= csr_data;
            REG_WIDTH:   width_ff   <= csr_data[DIM_W-1:0];
            REG_HEIGHT:  height_ff  <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Sizes beyond the frame store clamp to its side.
   always_comb begin
      cfg.coef_xx    = $signed(coef_xx_ff);
      cfg.coef_xy    = $signed(coef_xy_ff);
      cfg.coef_xt    = $signed(coef_xt_ff);
      cfg.coef_yx    = $signed(coef_yx_ff);
      cfg.coef_yy    = $signed(coef_yy_ff);
      cfg.coef_yt    = $signed(coef_yt_ff);
      cfg.eff_width  = (32'(width_ff) > MAX_SIDE) ? DIM_W'(MAX_SIDE) : width_ff;
      cfg.eff_height = (32'(height_ff) > MAX_SIDE) ? DIM_W'(MAX_SIDE) : height_ff;
   end

endmodule

// File: hdl/iawn_map.sv
// Affine mapping pipeline: products of coefficients and position, then the two sums.
// Depends on iawn_pkg.
module iawn_map
   import iawn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  item_type                 in_item,
   input  cfg_type                  cfg,
   output logic                     out_valid,
   output item_type                 out_item,
   output logic signed [SUM_W-1:0]  out_sx,
   output logic signed [SUM_W-1:0]  out_sy
);

   logic                     v1_ff, v1_in;
   item_type                 item1_ff, item1_in;
   logic signed [PROD_W-1:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff;
   logic signed [PROD_W-1:0] pxx_in, pxy_in, pyx_in, pyy_in;
   logic                     dest_out;
   logic                     v2_ff, v2_in;
   item_type                 item2_ff;
   logic signed [SUM_W-1:0]  sx_ff, sy_ff, sx_in, sy_in;

   always_comb begin
      v1_in    = in_valid;
      pxx_in   = cfg.coef_xx * $signed({1'b0, in_item.pos_x});
      pxy_in   = cfg.coef_xy * $signed({1'b0, in_item.pos_y});
      pyx_in   = cfg.coef_yx * $signed({1'b0, in_item.pos_x});
      pyy_in   = cfg.coef_yy * $signed({1'b0, in_item.pos_y});
      dest_out = (DIM_W'(in_item.pos_x) >= cfg.eff_width) ||
                 (DIM_W'(in_item.pos_y) >= cfg.eff_height);
      item1_in          = in_item;
      item1_in.dest_out = dest_out;
      v2_in    = v1_ff;
      sx_in    = SUM_W'(pxx_ff) + SUM_W'(pxy_ff) + SUM_W'(cfg.coef_xt);
      sy_in    = SUM_W'(pyx_ff) + SUM_W'(pyy_ff) + SUM_W'(cfg.coef_yt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item1_ff          <= item1_in;
         pxx_ff            <= pxx_in;
         pxy_ff            <= pxy_in;
         pyx_ff            <= pyx_in;
         pyy_ff            <= pyy_in;
         item2_ff          <= item1_ff;
         sx_ff             <= sx_in;
         sy_ff             <= sy_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item2_ff;
   assign out_sx    = sx_ff;
   assign out_sy    = sy_ff;

endmodule

// File: hdl/inverse_affine_warp_nearest.sv
// Inverse affine warp with nearest-neighbor fetch from an on-chip frame store.
// A warp result reaches rsp through the mapping registers and the output register. Throughput: one
// transaction per cycle, load or warp, while rsp does not stall; the frame store has one
// write and one read port, and each item uses at most one of them in the same pipeline slot.
// Reset clears the pipeline and restores the coefficients to identity and the size to
// 128 by 128; the frame store holds no defined contents until it is loaded.
module inverse_affine_warp_nearest
   import iawn_pkg::*;
#(
   parameter int MAX_SIDE  = 128,
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // pos_x[6:0], pos_y[13:7], pixel_in[37:14]
   input  logic                  req_tuser,   // mode
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // pixel_out[23:0]
   output logic                  rsp_tuser,   // outside
   // Configuration write channel.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [IDX_REG_W-1:0]  csr_index,
   input  logic [COEF_W-1:0]     csr_data
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(MAX_SIDE);

   cfg_type                 cfg;
   item_type                req_item;
   logic                    advance;

   logic                    v2;
   item_type                item2;
   logic signed [SUM_W-1:0] sx2, sy2;

   logic [SUM_W-1:0]        lim_x, lim_y;
   logic                    in_x, in_y;
   logic [IDX_W-1:0]        src_x, src_y;
   logic                    load_ok;
   logic                    fetch;
   logic                    wr_en, rd_en;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic [PIX_W-1:0]        rd_data;

   logic                    v4_ff, v4_in;
   logic                    out4_ff, out4_in;

   // The whole pipeline moves together; it stalls only when a result sits in the
   // output stage and the consumer does not take it.
   assign advance    = !v4_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      req_item.mode     = mode_type'(req_tuser);
      req_item.pos_x    = req_tdata[POS_W-1:0];
      req_item.pos_y    = req_tdata[2*POS_W-1:POS_W];
      req_item.pixel    = req_tdata[2*POS_W+PIX_W-1:2*POS_W];
      req_item.dest_out = 1'b0;
   end

   iawn_csr #(
      .MAX_SIDE  (MAX_SIDE),
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   iawn_map u_map (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_item   (req_item),
      .cfg       (cfg),
      .out_valid (v2),
      .out_item  (item2),
      .out_sx    (sx2),
      .out_sy    (sy2)
   );

   // Range check and frame store access. The source position must lie within
   // zero and side-1 in fixed point; a zero side rejects every position. Loads
   // and warp reads use the store in the same pipeline slot, so a warp always
   // sees every load that was accepted before it.
   always_comb begin
      lim_x   = (SUM_W'(cfg.eff_width) - SUM_W'(1)) << FRAC_BITS;
      lim_y   = (SUM_W'(cfg.eff_height) - SUM_W'(1)) << FRAC_BITS;
      in_x    = (cfg.eff_width != '0) && !sx2[SUM_W-1] && (SUM_W'(sx2) <= lim_x);
      in_y    = (cfg.eff_height != '0) && !sy2[SUM_W-1] && (SUM_W'(sy2) <= lim_y);
      src_x   = sx2[FRAC_BITS +: IDX_W];
      src_y   = sy2[FRAC_BITS +: IDX_W];
      fetch   = !item2.dest_out && in_x && in_y;
      load_ok = (32'(item2.pos_x) < MAX_SIDE) && (32'(item2.pos_y) < MAX_SIDE);

      wr_en   = advance && v2 && (item2.mode == MODE_LOAD) && load_ok;
      wr_addr = ADDR_W'(item2.pos_y) * ADDR_W'(MAX_SIDE) + ADDR_W'(item2.pos_x);
      rd_en   = advance && v2 && (item2.mode == MODE_WARP) && fetch;
      rd_addr = ADDR_W'(src_y) * ADDR_W'(MAX_SIDE) + ADDR_W'(src_x);

      v4_in   = v2 && (item2.mode == MODE_WARP);
      out4_in = !fetch;
   end

   iawn_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item2.pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out4_ff <= out4_in;
      end
   end

   // Output stage: the read data register of the store holds while stalled,
   // and an outside result shows black.
   assign rsp_tvalid = v4_ff;
   assign rsp_tuser  = out4_ff;
   assign rsp_tdata  = out4_ff ? '0 : rd_data;

endmodule
